### sv/srpc_pkg.sv
// Shared types, command codes and helpers for the servo ramp pulse controller.
// No dependencies; every other file but srpc_chk imports this package.
package srpc_pkg;

   // Command codes of an input item
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_SET     = 3'd1,
      CMD_RAMP    = 3'd2,
      CMD_ENABLE  = 3'd3,
      CMD_DISABLE = 3'd4,
      CMD_HOME    = 3'd5,
      CMD_ESTOP   = 3'd6,
      CMD_NONE    = 3'd7
   } cmd_type;

   // Register indexes on the config port (byte address is 4 * index)
   localparam logic [2:0] REG_MIN_PULSE = 3'd0;
   localparam logic [2:0] REG_MAX_PULSE = 3'd1;
   localparam logic [2:0] REG_MIN_ANGLE = 3'd2;
   localparam logic [2:0] REG_MAX_ANGLE = 3'd3;
   localparam logic [2:0] REG_HOME      = 3'd4;
   localparam logic [2:0] REG_INVERT    = 3'd5;

   // Divider widths: dividend magnitude and divisor
   localparam int NUM_W = 28;
   localparam int DEN_W = 16;
   localparam int CNT_W = 5;

   // Mirroring exists only for the first twelve servos
   localparam logic [3:0] INVERT_SERVOS = 4'd12;
   localparam logic [11:0] BUSY_TOL = 12'd16;

   typedef struct packed {
      logic [11:0] pulse_lo_us;
      logic [11:0] pulse_hi_us;
      logic [11:0] ang_lo;
      logic [11:0] ang_hi;
      logic [11:0] ang_park;
      logic [11:0] invert_mask;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;
      logic misc_exec;
      logic tick_step;
      logic ramp_take;
      logic home_on;
      logic write_go;
      logic push;
      logic next_idx;
      logic busy_clear;
      logic busy_step;
      logic emit_step;
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      cmd_type cmd;
      logic    ok;
      logic    ramp_act;
      logic    ramp_done;
      logic    servo_on;
      logic    idx_last;
      logic    res_none;
      logic    emit_last;
      logic    div_done;
   } sts_type;

   // Controller states, one-hot
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_TICK     = 9'b000000100,
      S_RDIV     = 9'b000001000,
      S_HOME     = 9'b000010000,
      S_WRITE    = 9'b000100000,
      S_PDIV     = 9'b001000000,
      S_NEXT     = 9'b010000000,
      S_BUSY     = 9'b100000000
   } state_type;

   // Clamp a signed angle request into [lo, hi], low bound checked first
   function automatic logic [11:0] clamp_angle(input logic signed [14:0] x,
                                               input logic [11:0] lo,
                                               input logic [11:0] hi);
      logic [11:0] r;
      if (x < $signed({3'b000, lo})) begin
         r = lo;
      end else if (x > $signed({3'b000, hi})) begin
         r = hi;
      end else begin
         r = x[11:0];
      end
      return r;
   endfunction

endpackage

### sv/srpc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on srpc_pkg for widths.
module srpc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [srpc_pkg::NUM_W-1:0] num,
   input  logic [srpc_pkg::DEN_W-1:0] den,
   output logic                       busy,
   output logic [srpc_pkg::NUM_W-1:0] quo
);
   import srpc_pkg::*;

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One shift-subtract step
   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      if (start) begin
         q_in   = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in   = {q_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = run_ff;
   assign quo  = q_ff;

endmodule

### sv/srpc_csr.sv
// Configuration registers behind the APB-style port.
// Depends on srpc_pkg for the register indexes and the config struct.
module srpc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output srpc_pkg::cfg_type   cfg
);
   import srpc_pkg::*;

   cfg_type    cfg_ff;
   logic       wr;
   logic [2:0] ridx;
   logic [11:0] rval;

   assign ridx   = paddr[4:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   // Register write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_lo_us <= 12'd500;
         cfg_ff.pulse_hi_us <= 12'd2500;
         cfg_ff.ang_lo      <= 12'd0;
         cfg_ff.ang_hi      <= 12'd2880;
         cfg_ff.ang_park    <= 12'd1440;
         cfg_ff.invert_mask <= 12'd0;
      end else if (wr) begin
         unique case (ridx)
            REG_MIN_PULSE: cfg_ff.pulse_lo_us <= pwdata[11:0];
            REG_MAX_PULSE: cfg_ff.pulse_hi_us <= pwdata[11:0];
            REG_MIN_ANGLE: cfg_ff.ang_lo      <= pwdata[11:0];
            REG_MAX_ANGLE: cfg_ff.ang_hi      <= pwdata[11:0];
            REG_HOME:      cfg_ff.ang_park    <= pwdata[11:0];
            REG_INVERT:    cfg_ff.invert_mask <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (ridx)
         REG_MIN_PULSE: rval = cfg_ff.pulse_lo_us;
         REG_MAX_PULSE: rval = cfg_ff.pulse_hi_us;
         REG_MIN_ANGLE: rval = cfg_ff.ang_lo;
         REG_MAX_ANGLE: rval = cfg_ff.ang_hi;
         REG_HOME:      rval = cfg_ff.ang_park;
         REG_INVERT:    rval = cfg_ff.invert_mask;
         default:       rval = '0;
      endcase
   end

   assign prdata = {20'd0, rval};
   assign cfg    = cfg_ff;

endmodule

### sv/srpc_ctrl.sv
// Sequencer for the servo controller: walks servos, waits on the divider,
// sweeps the busy flag and emits the buffered results. Depends on srpc_pkg.
module srpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              emit,
   input  srpc_pkg::sts_type sts,
   output srpc_pkg::ctl_type ctl
);
   import srpc_pkg::*;

   state_type st_ff, st_in;
   logic      emit_ff, emit_in;

   always_comb begin
      st_in   = st_ff;
      emit_in = emit_ff;
      ctl     = '0;
      if (emit_ff) begin
         // Draining the result buffer, one item per cycle
         ctl.emit_step = 1'b1;
         if (sts.emit_last) begin
            emit_in = 1'b0;
            st_in   = S_IDLE;
         end
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (start) begin
                  ctl.latch = 1'b1;
                  st_in     = S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               unique case (sts.cmd)
                  CMD_TICK: st_in = S_TICK;
                  CMD_SET:  st_in = sts.ok ? S_WRITE : S_IDLE;
                  CMD_HOME: st_in = S_HOME;
                  default: begin
                     ctl.misc_exec = 1'b1;
                     st_in         = S_IDLE;
                  end
               endcase
            end
            S_TICK: begin
               if (!sts.ramp_act) begin
                  st_in = S_NEXT;
               end else begin
                  ctl.tick_step = 1'b1;
                  st_in         = sts.ramp_done ? S_WRITE : S_RDIV;
               end
            end
            S_RDIV: begin
               if (sts.div_done) begin
                  ctl.ramp_take = 1'b1;
                  st_in         = S_WRITE;
               end
            end
            S_HOME: begin
               ctl.home_on = 1'b1;
               st_in       = S_WRITE;
            end
            S_WRITE: begin
               if (sts.servo_on) begin
                  ctl.write_go = 1'b1;
                  st_in        = S_PDIV;
               end else begin
                  st_in = S_NEXT;
               end
            end
            S_PDIV: begin
               if (sts.div_done) begin
                  ctl.push = 1'b1;
                  st_in    = S_NEXT;
               end
            end
            S_NEXT: begin
               if (sts.cmd == CMD_SET || sts.idx_last) begin
                  if (sts.res_none) begin
                     st_in = S_IDLE;
                  end else begin
                     ctl.busy_clear = 1'b1;
                     st_in          = S_BUSY;
                  end
               end else begin
                  ctl.next_idx = 1'b1;
                  st_in        = (sts.cmd == CMD_TICK) ? S_TICK : S_HOME;
               end
            end
            S_BUSY: begin
               ctl.busy_step = 1'b1;
               if (sts.idx_last) begin
                  emit_in = 1'b1;
               end
            end
            default: st_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         emit_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         emit_ff <= emit_in;
      end
   end

   assign busy = (st_ff != S_IDLE) | emit_ff;
   assign emit = emit_ff;

endmodule

### sv/srpc_dp.sv
// Datapath: per-servo state, ramp interpolation, clamp, mirror, pulse map
// and the result buffer. Depends on srpc_pkg and srpc_div.
module srpc_dp #(
   parameter int SERVO_COUNT = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  srpc_pkg::ctl_type   ctl,
   output srpc_pkg::sts_type   sts,
   input  srpc_pkg::cfg_type   cfg,
   input  logic [2:0]          req_cmd,
   input  logic [3:0]          req_servo_index,
   input  logic signed [12:0]  req_angle,
   input  logic [15:0]         req_duration_ms,
   output logic [3:0]          rsp_servo_index_res,
   output logic [11:0]         rsp_pulse_us,
   output logic [11:0]         rsp_angle_res,
   output logic                rsp_busy_res,
   output logic                rsp_last
);
   import srpc_pkg::*;

   localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam int CW = $clog2(SERVO_COUNT + 1);
   localparam logic [3:0] LAST_IDX = 4'(SERVO_COUNT - 1);

   // Item registers
   cmd_type            cmd_ff;
   logic [3:0]         idx_ff;
   logic               ok_ff;
   logic signed [12:0] ang_ff;
   logic [15:0]        dur_ff;
   logic signed [14:0] req_ff;
   logic [11:0]        a_ff;
   logic               neg_ff;
   logic               flat_ff;
   logic               bacc_ff;
   logic [CW-1:0]      n_ff;
   logic [CW-1:0]      ptr_ff;

   // Per-servo state
   logic [11:0] cur_ff   [SERVO_COUNT];
   logic [11:0] tgt_ff   [SERVO_COUNT];
   logic        on_ff    [SERVO_COUNT];
   logic        act_ff   [SERVO_COUNT];
   logic [11:0] rst_ff   [SERVO_COUNT];
   logic [11:0] rend_ff  [SERVO_COUNT];
   logic [15:0] el_ff    [SERVO_COUNT];
   logic [15:0] len_ff   [SERVO_COUNT];

   // Result buffer
   logic [3:0]  res_idx_ff [SERVO_COUNT];
   logic [11:0] res_pls_ff [SERVO_COUNT];
   logic [11:0] res_ang_ff [SERVO_COUNT];

   logic [IW-1:0]      ix;
   logic [IW-1:0]      px;
   logic [15:0]        el_new;
   logic               rdone;
   logic signed [12:0] d;
   logic [11:0]        d_mag;
   logic [NUM_W-1:0]   ramp_num;
   logic [11:0]        a_cl;
   logic [11:0]        ramp_t;
   logic [15:0]        mask16;
   logic               inv;
   logic signed [14:0] lo15;
   logic signed [14:0] m;
   logic signed [14:0] diff;
   logic [13:0]        diff_mag;
   logic signed [12:0] pr;
   logic signed [12:0] ar;
   logic [11:0]        pr_mag;
   logic [11:0]        ar_mag;
   logic [NUM_W-1:0]   pulse_num;
   logic               div_start;
   logic [NUM_W-1:0]   div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_busy;
   logic [NUM_W-1:0]   quo;
   logic [NUM_W-1:0]   q_s;
   logic [11:0]        pulse;
   logic [11:0]        adiff;
   logic               bcond;

   assign ix = idx_ff[IW-1:0];
   assign px = ptr_ff[IW-1:0];

   // Ramp step for the current servo
   assign el_new   = (el_ff[ix] == 16'hFFFF) ? el_ff[ix] : el_ff[ix] + 16'd1;
   assign rdone    = el_new >= len_ff[ix];
   assign d        = $signed({1'b0, rend_ff[ix]}) - $signed({1'b0, rst_ff[ix]});
   assign d_mag    = d[12] ? 12'(-d) : d[11:0];
   assign ramp_num = NUM_W'(d_mag) * NUM_W'(el_new);

   // Clamp, mirror and pulse map
   assign a_cl   = clamp_angle(req_ff, cfg.ang_lo, cfg.ang_hi);
   assign ramp_t = clamp_angle(15'(ang_ff), cfg.ang_lo, cfg.ang_hi);
   assign mask16 = {4'd0, cfg.invert_mask};
   assign inv    = (idx_ff < INVERT_SERVOS) && mask16[idx_ff];
   assign lo15   = $signed({3'b000, cfg.ang_lo});
   assign m      = inv ? ($signed({3'b000, cfg.ang_hi}) - $signed({3'b000, a_cl}) + lo15)
                       : $signed({3'b000, a_cl});
   assign diff   = m - lo15;
   assign diff_mag = diff[14] ? 14'(-diff) : diff[13:0];
   assign pr     = $signed({1'b0, cfg.pulse_hi_us}) - $signed({1'b0, cfg.pulse_lo_us});
   assign ar     = $signed({1'b0, cfg.ang_hi}) - $signed({1'b0, cfg.ang_lo});
   assign pr_mag = pr[12] ? 12'(-pr) : pr[11:0];
   assign ar_mag = ar[12] ? 12'(-ar) : ar[11:0];
   assign pulse_num = NUM_W'(diff_mag) * NUM_W'(pr_mag);

   // Shared divider
   assign div_start = (ctl.tick_step & ~rdone) | (ctl.write_go & (ar != '0));
   assign div_num   = ctl.write_go ? pulse_num : ramp_num;
   assign div_den   = ctl.write_go ? DEN_W'(ar_mag) : len_ff[ix];

   srpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign q_s   = neg_ff ? NUM_W'(-quo) : quo;
   assign pulse = flat_ff ? cfg.pulse_lo_us : cfg.pulse_lo_us + q_s[11:0];

   // Busy condition for the swept servo
   assign adiff = (cur_ff[ix] > tgt_ff[ix]) ? cur_ff[ix] - tgt_ff[ix]
                                            : tgt_ff[ix] - cur_ff[ix];
   assign bcond = act_ff[ix] | (adiff > BUSY_TOL);

   // Item registers and sequencing counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff <= CMD_NONE;
         idx_ff <= '0;
         n_ff   <= '0;
         ptr_ff <= '0;
      end else begin
         if (ctl.latch) begin
            cmd_ff <= cmd_type'(req_cmd);
            idx_ff <= (cmd_type'(req_cmd) == CMD_TICK || cmd_type'(req_cmd) == CMD_HOME)
                      ? 4'd0 : req_servo_index;
            n_ff   <= '0;
            ptr_ff <= '0;
         end
         if (ctl.next_idx || ctl.busy_step) begin
            idx_ff <= idx_ff + 4'd1;
         end
         if (ctl.busy_clear) begin
            idx_ff <= '0;
         end
         if (ctl.push) begin
            n_ff <= n_ff + 1'b1;
         end
         if (ctl.emit_step) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   // Payload registers of the item
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         ok_ff  <= {1'b0, req_servo_index} < 5'(SERVO_COUNT);
         ang_ff <= req_angle;
         dur_ff <= req_duration_ms;
         req_ff <= 15'(req_angle);
      end
      if (ctl.tick_step) begin
         req_ff <= $signed({3'b000, rend_ff[ix]});
         neg_ff <= d[12];
      end
      if (ctl.ramp_take) begin
         req_ff <= $signed({3'b000, rst_ff[ix]}) + $signed(q_s[14:0]);
      end
      if (ctl.home_on) begin
         req_ff <= $signed({3'b000, cfg.ang_park});
      end
      if (ctl.write_go) begin
         a_ff    <= a_cl;
         flat_ff <= (ar == '0);
         neg_ff  <= diff[14] ^ pr[12] ^ ar[12];
      end
      if (ctl.busy_clear) begin
         bacc_ff <= 1'b0;
      end
      if (ctl.busy_step) begin
         bacc_ff <= bacc_ff | bcond;
      end
      if (ctl.push) begin
         res_idx_ff[n_ff[IW-1:0]] <= idx_ff;
         res_pls_ff[n_ff[IW-1:0]] <= pulse;
         res_ang_ff[n_ff[IW-1:0]] <= a_ff;
      end
   end

   // Per-servo state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SERVO_COUNT; i++) begin
            cur_ff[i] <= 12'd1440;
            tgt_ff[i] <= 12'd1440;
            on_ff[i]  <= 1'b0;
            act_ff[i] <= 1'b0;
         end
      end else begin
         if (ctl.tick_step) begin
            el_ff[ix] <= el_new;
            if (rdone) begin
               act_ff[ix] <= 1'b0;
            end
         end
         if (ctl.home_on) begin
            on_ff[ix] <= 1'b1;
         end
         if (ctl.write_go) begin
            cur_ff[ix] <= a_cl;
            tgt_ff[ix] <= a_cl;
         end
         if (ctl.misc_exec) begin
            case (cmd_ff)
               CMD_RAMP: begin
                  if (ok_ff) begin
                     act_ff[ix]  <= 1'b1;
                     rst_ff[ix]  <= cur_ff[ix];
                     rend_ff[ix] <= ramp_t;
                     tgt_ff[ix]  <= ramp_t;
                     el_ff[ix]   <= '0;
                     len_ff[ix]  <= dur_ff;
                  end
               end
               CMD_ENABLE: begin
                  if (ok_ff) begin
                     on_ff[ix] <= 1'b1;
                  end
               end
               CMD_DISABLE: begin
                  if (ok_ff) begin
                     on_ff[ix] <= 1'b0;
                  end
               end
               CMD_ESTOP: begin
                  for (int i = 0; i < SERVO_COUNT; i++) begin
                     on_ff[i]  <= 1'b0;
                     act_ff[i] <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Status back to the sequencer
   assign sts.cmd       = cmd_ff;
   assign sts.ok        = ok_ff;
   assign sts.ramp_act  = act_ff[ix];
   assign sts.ramp_done = rdone;
   assign sts.servo_on  = on_ff[ix];
   assign sts.idx_last  = (idx_ff == LAST_IDX);
   assign sts.res_none  = (n_ff == '0);
   assign sts.emit_last = (ptr_ff == CW'(n_ff - 1'b1));
   assign sts.div_done  = ~div_busy;

   // Result item from the buffer
   assign rsp_servo_index_res = res_idx_ff[px];
   assign rsp_pulse_us        = res_pls_ff[px];
   assign rsp_angle_res       = res_ang_ff[px];
   assign rsp_busy_res        = bacc_ff;
   assign rsp_last            = (ptr_ff == CW'(n_ff - 1'b1));

endmodule

### sv/servo_ramp_pulse_controller.sv
// Top level of the servo ramp pulse controller.
// Depends on srpc_pkg, srpc_csr, srpc_ctrl, srpc_dp (and srpc_div below it).
//
// Usage:
//  - Input channel: drive req_* and raise start; the item is taken at a clock
//    edge where start is high and busy is low. busy stays high until every
//    result of the item has been shown.
//  - Result channel: rsp_strobe marks one result item per cycle; the results
//    of one item come in consecutive cycles, rsp_last on the final one. The
//    receiver cannot stall; each result is shown for exactly one cycle.
//  - Config port: APB-style, registers at byte address 4*index, pready tied
//    high. Write only while busy is low.
//  - Sequence: enable, disable, ramp, stop and ignored commands finish
//    without the divider. Each servo written runs a pulse division unless
//    the angle range is zero; a ramp step that does not end the ramp runs
//    a ramp division before it. Once results exist a busy sweep over every
//    servo runs, then the results are shown. Both divisions share the
//    single bit-serial divider.
//  - Reset: all servos disabled, no ramps, angles at 1440, registers at
//    their documented defaults.
module servo_ramp_pulse_controller #(
   parameter int SERVO_COUNT = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [3:0]         req_servo_index,
   input  logic signed [12:0] req_angle,
   input  logic [15:0]        req_duration_ms,
   output logic               rsp_strobe,
   output logic [3:0]         rsp_servo_index_res,
   output logic [11:0]        rsp_pulse_us,
   output logic [11:0]        rsp_angle_res,
   output logic               rsp_busy_res,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import srpc_pkg::*;

   cfg_type cfg;
   ctl_type ctl;
   sts_type sts;

   srpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srpc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .emit  (rsp_strobe),
      .sts   (sts),
      .ctl   (ctl)
   );

   srpc_dp #(.SERVO_COUNT(SERVO_COUNT)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .sts                 (sts),
      .cfg                 (cfg),
      .req_cmd             (req_cmd),
      .req_servo_index     (req_servo_index),
      .req_angle           (req_angle),
      .req_duration_ms     (req_duration_ms),
      .rsp_servo_index_res (rsp_servo_index_res),
      .rsp_pulse_us        (rsp_pulse_us),
      .rsp_angle_res       (rsp_angle_res),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_last            (rsp_last)
   );

endmodule

### sv/srpc_chk.sv
// Port-level checks for the servo ramp pulse controller, bound to the top.
// Depends only on the top level's port names.
module srpc_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last,
   input logic rsp_busy_res
);

   // Results only appear while an item is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result shown while idle");

   // An accepted item always makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Results of one item are contiguous
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a result burst");

   // The busy flag is the same across one item's results
   a_busy_same: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_busy_res == $past(rsp_busy_res))
      else $error("busy_res changed within an item");

   // The block goes idle right after the last result
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !busy)
      else $error("still busy after last result");

endmodule

bind servo_ramp_pulse_controller srpc_chk u_chk (.*);
